// ===== design/bfg_pkg.sv =====
// Shared types, constants and discharge curve table of the battery fuel gauge.
package bfg_pkg;

  // Defaults of the top-level parameters
  localparam int OVERSAMPLE_DEF = 9;
  localparam int SMOOTH_SHIFT_DEF = 3;
  localparam int MIN_PLAUSIBLE_MV_DEF = 2500;
  localparam int MAX_PLAUSIBLE_MV_DEF = 4500;

  // Configuration register indexes
  localparam logic [3:0] REG_ENABLE   = 4'd0;
  localparam logic [3:0] REG_DIVIDER  = 4'd1;
  localparam logic [3:0] REG_TRIM     = 4'd2;
  localparam logic [3:0] REG_CELLS    = 4'd3;
  localparam logic [3:0] REG_FULL     = 4'd4;
  localparam logic [3:0] REG_EMPTY    = 4'd5;
  localparam logic [3:0] REG_LOW      = 4'd6;
  localparam logic [3:0] REG_CRITICAL = 4'd7;

  // Gauge state codes
  localparam logic [2:0] GS_UNKNOWN     = 3'd0;
  localparam logic [2:0] GS_CHARGING    = 3'd1;
  localparam logic [2:0] GS_FULL        = 3'd2;
  localparam logic [2:0] GS_CRITICAL    = 3'd3;
  localparam logic [2:0] GS_LOW         = 3'd4;
  localparam logic [2:0] GS_DISCHARGING = 3'd5;

  // Divider widths
  localparam int NUM_W = 24;
  localparam int DEN_W = 13;

  // Discharge curve knees
  localparam int KNEES = 14;
  localparam logic [12:0] CURVE_FLOOR_MV = 13'd3000;
  localparam logic [12:0] KNEE_MV [KNEES] = '{
    13'd4150, 13'd4050, 13'd3970, 13'd3910, 13'd3850, 13'd3800, 13'd3750,
    13'd3710, 13'd3680, 13'd3640, 13'd3590, 13'd3520, 13'd3450, 13'd3350};
  localparam logic [9:0] KNEE_MILLI [KNEES] = '{
    10'd1000, 10'd920, 10'd850, 10'd770, 10'd680, 10'd590, 10'd500,
    10'd410, 10'd330, 10'd250, 10'd170, 10'd100, 10'd50, 10'd10};

  // Step selector for the shared divide stages
  typedef enum logic [2:0] {
    OP_CELL = 3'd0,
    OP_HERE = 3'd1,
    OP_TOP  = 3'd2,
    OP_BOT  = 3'd3,
    OP_PCT  = 3'd4
  } op_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic store;
    logic clr_smooth;
    logic med_check;
    logic mul1;
    logic mul2;
    logic smooth;
    logic div_start;
    logic latch;
    logic use_div;
    logic load_out;
    op_t  op;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic enabled;
    logic present;
    logic direct;
    logic div_done;
  } status_t;

endpackage

// ===== design/battery_fuel_gauge_core.sv =====
// Top level of the battery fuel gauge: controller, datapath and stream ports.
// A conversion that does not fill a burst is taken while idle; the one that fills it starts
// median, scaling, smoothing and up to five divide steps, during which no input is taken.
// Throughput: one conversion per cycle otherwise; a reading still unread holds back the next.
// Reset (synchronous, rst_n low): registers at defaults, burst count and smoothing cleared.
module battery_fuel_gauge_core #(
  parameter int OVERSAMPLE       = bfg_pkg::OVERSAMPLE_DEF,
  parameter int SMOOTH_SHIFT     = bfg_pkg::SMOOTH_SHIFT_DEF,
  parameter int MIN_PLAUSIBLE_MV = bfg_pkg::MIN_PLAUSIBLE_MV_DEF,
  parameter int MAX_PLAUSIBLE_MV = bfg_pkg::MAX_PLAUSIBLE_MV_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [13:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // pin_mv[11:0], charging_level[12], charge_done_level[13]
  input  logic        in_tuser,  // burst_start
  output logic        out_tvalid,
  input  logic        out_tready,
  // present[0], gauge_state[3:1], pack_mv[18:4], cell_mv[31:19], percent[38:32],
  // low_flag[39], critical_flag[40], median_pin_mv[52:41], charging[53], charge_done[54]
  output logic [55:0] out_tdata
);

  localparam int IW = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;

  bfg_pkg::cmd_t    cmd;
  bfg_pkg::status_t status;
  logic [IW-1:0]    wr_addr, med_idx;

  bfg_ctrl #(
    .OVERSAMPLE (OVERSAMPLE)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .burst_start (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .status      (status),
    .cmd         (cmd),
    .wr_addr     (wr_addr),
    .med_idx     (med_idx)
  );

  bfg_dp #(
    .OVERSAMPLE       (OVERSAMPLE),
    .SMOOTH_SHIFT     (SMOOTH_SHIFT),
    .MIN_PLAUSIBLE_MV (MIN_PLAUSIBLE_MV),
    .MAX_PLAUSIBLE_MV (MAX_PLAUSIBLE_MV)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .pin_mv            (in_tdata[11:0]),
    .charging_level    (in_tdata[12]),
    .charge_done_level (in_tdata[13]),
    .wr_addr           (wr_addr),
    .med_idx           (med_idx),
    .cmd               (cmd),
    .status            (status),
    .out_data          (out_tdata)
  );

endmodule

// ===== design/bfg_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module bfg_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bfg_pkg::NUM_W-1:0] num,
  input  logic [bfg_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [bfg_pkg::NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(bfg_pkg::NUM_W + 1);

  logic [bfg_pkg::NUM_W-1:0] q_r, q_nxt;
  logic [bfg_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [bfg_pkg::DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [bfg_pkg::DEN_W:0]   trial;

  // One shift-subtract step per cycle
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[bfg_pkg::NUM_W-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(bfg_pkg::NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = bfg_pkg::DEN_W'(trial - {1'b0, den_r});
        q_nxt   = {q_r[bfg_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[bfg_pkg::DEN_W-1:0];
        q_nxt   = {q_r[bfg_pkg::NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== design/bfg_dp.sv =====
// Datapath: configuration, burst store, median, scaling, smoothing, curve and output register.
module bfg_dp #(
  parameter int OVERSAMPLE       = bfg_pkg::OVERSAMPLE_DEF,
  parameter int SMOOTH_SHIFT     = bfg_pkg::SMOOTH_SHIFT_DEF,
  parameter int MIN_PLAUSIBLE_MV = bfg_pkg::MIN_PLAUSIBLE_MV_DEF,
  parameter int MAX_PLAUSIBLE_MV = bfg_pkg::MAX_PLAUSIBLE_MV_DEF,
  localparam int IW = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_index,
  input  logic [13:0]         cfg_wdata,
  input  logic [11:0]         pin_mv,
  input  logic                charging_level,
  input  logic                charge_done_level,
  input  logic [IW-1:0]       wr_addr,
  input  logic [IW-1:0]       med_idx,
  input  bfg_pkg::cmd_t       cmd,
  output bfg_pkg::status_t    status,
  output logic [55:0]         out_data
);

  localparam int CW = $clog2(OVERSAMPLE + 1);
  localparam logic [CW-1:0] MED_K = CW'(OVERSAMPLE / 2);

  // Configuration registers
  logic        en_r;
  logic [12:0] div_r, full_r, empty_r;
  logic [13:0] trim_r;
  logic [2:0]  cells_r;
  logic [6:0]  low_r;
  logic [5:0]  crit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b1;
      div_r   <= 13'd512;
      trim_r  <= 14'd4096;
      cells_r <= 3'd1;
      full_r  <= 13'd4150;
      empty_r <= 13'd3300;
      low_r   <= 7'd20;
      crit_r  <= 6'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bfg_pkg::REG_ENABLE:   en_r    <= cfg_wdata[0];
        bfg_pkg::REG_DIVIDER:  div_r   <= cfg_wdata[12:0];
        bfg_pkg::REG_TRIM:     trim_r  <= cfg_wdata[13:0];
        bfg_pkg::REG_CELLS:    cells_r <= cfg_wdata[2:0];
        bfg_pkg::REG_FULL:     full_r  <= cfg_wdata[12:0];
        bfg_pkg::REG_EMPTY:    empty_r <= cfg_wdata[12:0];
        bfg_pkg::REG_LOW:      low_r   <= cfg_wdata[6:0];
        bfg_pkg::REG_CRITICAL: crit_r  <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // Effective settings with fallbacks
  logic [12:0] div_e, full_e, empty_e;
  logic [13:0] trim_e;
  logic [2:0]  cells_e;
  logic [5:0]  crit_e;
  logic [6:0]  low_e;

  always_comb begin
    div_e   = (div_r >= 13'd256 && div_r <= 13'd5120) ? div_r : 13'd512;
    trim_e  = (trim_r >= 14'd2048 && trim_r <= 14'd8192) ? trim_r : 14'd4096;
    cells_e = (cells_r >= 3'd1 && cells_r <= 3'd4) ? cells_r : 3'd1;
    full_e  = (full_r >= 13'd3400 && full_r <= 13'd4500) ? full_r : 13'd4150;
    if (empty_r >= 13'd2500 && ({1'b0, empty_r} + 14'd50) < {1'b0, full_e})
      empty_e = empty_r;
    else if (13'd3350 < full_e)
      empty_e = 13'd3300;
    else
      empty_e = full_e - 13'd500;
    crit_e = (crit_r <= 6'd50) ? crit_r : 6'd10;
    low_e  = (low_r <= 7'd90 && low_r > {1'b0, crit_e}) ? low_r : 7'd20;
    if (low_e <= {1'b0, crit_e})
      low_e = ({1'b0, crit_e} + 7'd5 < 7'd90) ? {1'b0, crit_e} + 7'd5 : 7'd90;
  end

  // Burst sample store and levels of the last conversion
  logic [11:0] samp_r [OVERSAMPLE];
  logic        chg_r, done_r;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      samp_r[wr_addr] <= pin_mv;
      chg_r           <= charging_level;
      done_r          <= charge_done_level;
    end
  end

  // Median by rank: candidate whose rank brackets the middle position
  logic [11:0]   cand;
  logic [CW-1:0] n_lt, n_le;
  logic [11:0]   median_r;

  always_comb begin
    cand = samp_r[med_idx];
    n_lt = '0;
    n_le = '0;
    for (int i = 0; i < OVERSAMPLE; i++) begin
      n_lt = n_lt + CW'(samp_r[i] < cand);
      n_le = n_le + CW'(samp_r[i] <= cand);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.med_check && n_lt <= MED_K && n_le > MED_K) median_r <= cand;
  end

  // Scaling products, one multiplier per stage
  logic [24:0] prod1_r;
  logic [38:0] prod2_r;
  logic [19:0] raw;
  logic [19:0] lo_lim, hi_lim;
  logic        present_c;

  always_ff @(posedge clk) begin
    if (cmd.mul1) prod1_r <= 25'(median_r) * 25'(div_e);
    if (cmd.mul2) prod2_r <= 39'(prod1_r) * 39'(trim_e);
  end

  assign raw       = 20'((prod2_r + 39'd524288) >> 20);
  assign lo_lim    = 20'(MIN_PLAUSIBLE_MV) * 20'(cells_e);
  assign hi_lim    = 20'(MAX_PLAUSIBLE_MV) * 20'(cells_e);
  assign present_c = (raw >= lo_lim) && (raw <= hi_lim);

  // Exponential smoothing of pack millivolts in Q.8
  logic [23:0] smooth_r, smooth_nxt, r8;
  logic        present_r;
  logic        cfg_hit;

  assign r8      = {raw[15:0], 8'd0};
  assign cfg_hit = cfg_we && (cfg_index <= bfg_pkg::REG_CRITICAL);

  always_comb begin
    smooth_nxt = smooth_r;
    if (cfg_hit || cmd.clr_smooth) begin
      smooth_nxt = '0;
    end else if (cmd.smooth) begin
      if (!present_c)
        smooth_nxt = '0;
      else if (smooth_r == '0)
        smooth_nxt = r8;
      else if (r8 >= smooth_r)
        smooth_nxt = smooth_r + ((r8 - smooth_r) >> SMOOTH_SHIFT);
      else
        smooth_nxt = smooth_r - ((smooth_r - r8) >> SMOOTH_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) smooth_r <= '0;
    else smooth_r <= smooth_nxt;
    if (cmd.smooth) present_r <= present_c;
  end

  // Curve segment of the selected voltage
  logic [16:0]              cell_r;
  logic [9:0]               here_r, top_r, bot_r;
  logic [6:0]               pct_r;
  logic [16:0]              cv;
  logic                     cv_direct;
  logic [9:0]               cv_val, cv_base;
  logic [bfg_pkg::NUM_W-1:0] cv_num;
  logic [bfg_pkg::DEN_W-1:0] cv_den;
  logic [12:0]              seg_span;
  logic [16:0]              seg_part;
  logic [9:0]               seg_rise;

  always_comb begin
    unique case (cmd.op)
      bfg_pkg::OP_TOP: cv = 17'(full_e);
      bfg_pkg::OP_BOT: cv = 17'(empty_e);
      default:         cv = cell_r;
    endcase
    cv_direct = 1'b0;
    cv_val    = '0;
    cv_base   = '0;
    seg_span  = 13'd350;
    seg_part  = cv - 17'(bfg_pkg::CURVE_FLOOR_MV);
    seg_rise  = bfg_pkg::KNEE_MILLI[bfg_pkg::KNEES-1];
    for (int i = bfg_pkg::KNEES - 1; i >= 1; i--) begin
      if (cv >= 17'(bfg_pkg::KNEE_MV[i])) begin
        seg_span = bfg_pkg::KNEE_MV[i-1] - bfg_pkg::KNEE_MV[i];
        seg_part = cv - 17'(bfg_pkg::KNEE_MV[i]);
        seg_rise = bfg_pkg::KNEE_MILLI[i-1] - bfg_pkg::KNEE_MILLI[i];
        cv_base  = bfg_pkg::KNEE_MILLI[i];
      end
    end
    if (cv >= 17'(bfg_pkg::KNEE_MV[0])) begin
      cv_direct = 1'b1;
      cv_val    = 10'd1000;
    end else if (cv <= 17'(bfg_pkg::CURVE_FLOOR_MV)) begin
      cv_direct = 1'b1;
      cv_val    = '0;
    end
    cv_num = bfg_pkg::NUM_W'(seg_rise) * bfg_pkg::NUM_W'(seg_part)
           + bfg_pkg::NUM_W'(seg_span >> 1);
    cv_den = seg_span;
  end

  // Percent rescale between curve points, or straight line on collapse
  logic                      pct_direct;
  logic [6:0]                pct_val;
  logic [bfg_pkg::NUM_W-1:0] pct_num;
  logic [bfg_pkg::DEN_W-1:0] pct_den;
  logic [12:0]               line_span;
  logic [9:0]                rng;

  always_comb begin
    line_span  = full_e - empty_e;
    rng        = top_r - bot_r;
    pct_direct = 1'b0;
    pct_val    = '0;
    if (top_r <= bot_r) begin
      pct_num = bfg_pkg::NUM_W'(cell_r - 17'(empty_e)) * bfg_pkg::NUM_W'(100)
              + bfg_pkg::NUM_W'(line_span >> 1);
      pct_den = line_span;
    end else begin
      pct_num = bfg_pkg::NUM_W'(here_r - bot_r) * bfg_pkg::NUM_W'(100)
              + bfg_pkg::NUM_W'(rng >> 1);
      pct_den = bfg_pkg::DEN_W'(rng);
    end
    if (cell_r >= 17'(full_e)) begin
      pct_direct = 1'b1;
      pct_val    = 7'd100;
    end else if (cell_r <= 17'(empty_e)) begin
      pct_direct = 1'b1;
    end else if (top_r > bot_r && here_r <= bot_r) begin
      pct_direct = 1'b1;
    end
  end

  // Shared divider
  logic [bfg_pkg::NUM_W-1:0] div_num, quo;
  logic [bfg_pkg::DEN_W-1:0] div_den;
  logic                      div_done;
  logic                      direct;

  always_comb begin
    unique case (cmd.op)
      bfg_pkg::OP_CELL: begin
        div_num = smooth_r;
        div_den = bfg_pkg::DEN_W'(cells_e);
        direct  = 1'b0;
      end
      bfg_pkg::OP_PCT: begin
        div_num = pct_num;
        div_den = pct_den;
        direct  = pct_direct;
      end
      default: begin
        div_num = cv_num;
        div_den = cv_den;
        direct  = cv_direct;
      end
    endcase
  end

  bfg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  // Store the result of a curve step
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      unique case (cmd.op)
        bfg_pkg::OP_CELL: cell_r <= 17'((25'(quo) + 25'd128) >> 8);
        bfg_pkg::OP_HERE: here_r <= cmd.use_div ? cv_base + 10'(quo) : cv_val;
        bfg_pkg::OP_TOP:  top_r  <= cmd.use_div ? cv_base + 10'(quo) : cv_val;
        bfg_pkg::OP_BOT:  bot_r  <= cmd.use_div ? cv_base + 10'(quo) : cv_val;
        bfg_pkg::OP_PCT:  pct_r  <= !cmd.use_div ? pct_val :
                                    (quo > 24'd100) ? 7'd100 : 7'(quo);
        default: ;
      endcase
    end
  end

  // Flags, state and output register
  logic [16:0] pack;
  logic        lowf, critf;
  logic [2:0]  gstate;
  logic [55:0] out_r;

  always_comb begin
    pack  = 17'((25'(smooth_r) + 25'd128) >> 8);
    lowf  = !chg_r && (pct_r <= low_e);
    critf = !chg_r && (pct_r <= 7'(crit_e));
    priority if (chg_r)                      gstate = bfg_pkg::GS_CHARGING;
    else if (done_r && pct_r >= 7'd95)       gstate = bfg_pkg::GS_FULL;
    else if (critf)                          gstate = bfg_pkg::GS_CRITICAL;
    else if (lowf)                           gstate = bfg_pkg::GS_LOW;
    else                                     gstate = bfg_pkg::GS_DISCHARGING;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (present_r)
        out_r <= {1'b0, done_r, chg_r, median_r, critf, lowf, pct_r,
                  cell_r[12:0], pack[14:0], gstate, 1'b1};
      else
        out_r <= {1'b0, done_r, chg_r, median_r, 2'b00, 7'd0,
                  13'd0, 15'd0, bfg_pkg::GS_UNKNOWN, 1'b0};
    end
  end

  assign out_data        = out_r;
  assign status.enabled  = en_r;
  assign status.present  = present_c;
  assign status.direct   = direct;
  assign status.div_done = div_done;

endmodule

// ===== design/bfg_ctrl.sv =====
// Controller: burst counting, step sequencing and output handshake.
module bfg_ctrl #(
  parameter int OVERSAMPLE = bfg_pkg::OVERSAMPLE_DEF,
  localparam int IW = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             burst_start,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  bfg_pkg::status_t status,
  output bfg_pkg::cmd_t    cmd,
  output logic [IW-1:0]    wr_addr,
  output logic [IW-1:0]    med_idx
);

  localparam int CW = $clog2(OVERSAMPLE + 1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_MED    = 11'b000_0000_0010,
    S_MUL1   = 11'b000_0000_0100,
    S_MUL2   = 11'b000_0000_1000,
    S_SMOOTH = 11'b000_0001_0000,
    S_CELL   = 11'b000_0010_0000,
    S_HERE   = 11'b000_0100_0000,
    S_TOP    = 11'b000_1000_0000,
    S_BOT    = 11'b001_0000_0000,
    S_PCT    = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          wait_r, wait_nxt;
  logic          ov_r, ov_nxt;
  logic          acc;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    wait_nxt  = wait_r;
    ov_nxt    = (ov_r && out_tready) ? 1'b0 : ov_r;
    cmd       = '0;
    cmd.op    = bfg_pkg::OP_CELL;
    unique case (state_r)
      // Take conversions; the burst-filling one starts the computation
      S_IDLE: begin
        if (acc) begin
          priority if (!status.enabled) begin
            cmd.clr_smooth = 1'b1;
            cnt_nxt        = '0;
          end else if (burst_start) begin
            cnt_nxt = '0;
          end else if (cnt_r < CW'(OVERSAMPLE)) begin
            cmd.store = 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
            if (cnt_r == CW'(OVERSAMPLE - 1)) begin
              state_nxt = S_MED;
              idx_nxt   = '0;
            end
          end else begin
            cnt_nxt = cnt_r;
          end
        end
      end
      // One rank test per sample
      S_MED: begin
        cmd.med_check = 1'b1;
        idx_nxt       = idx_r + 1'b1;
        if (idx_r == IW'(OVERSAMPLE - 1)) state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_SMOOTH;
      end
      S_SMOOTH: begin
        cmd.smooth = 1'b1;
        state_nxt  = status.present ? S_CELL : S_OUT;
      end
      // Divide steps: direct value or one divider run each
      S_CELL, S_HERE, S_TOP, S_BOT, S_PCT: begin
        unique case (state_r)
          S_CELL:  cmd.op = bfg_pkg::OP_CELL;
          S_HERE:  cmd.op = bfg_pkg::OP_HERE;
          S_TOP:   cmd.op = bfg_pkg::OP_TOP;
          S_BOT:   cmd.op = bfg_pkg::OP_BOT;
          default: cmd.op = bfg_pkg::OP_PCT;
        endcase
        if (!wait_r && status.direct) begin
          cmd.latch = 1'b1;
        end else if (!wait_r) begin
          cmd.div_start = 1'b1;
          wait_nxt      = 1'b1;
        end else if (status.div_done) begin
          cmd.latch   = 1'b1;
          cmd.use_div = 1'b1;
          wait_nxt    = 1'b0;
        end
        if (cmd.latch) begin
          unique case (state_r)
            S_CELL:  state_nxt = S_HERE;
            S_HERE:  state_nxt = S_TOP;
            S_TOP:   state_nxt = S_BOT;
            S_BOT:   state_nxt = S_PCT;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      // Load the output register once it is free
      S_OUT: begin
        if (!ov_r || out_tready) begin
          cmd.load_out = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      wait_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      wait_r  <= wait_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign wr_addr    = cnt_r[IW-1:0];
  assign med_idx    = idx_r;
  assign out_tvalid = ov_r;

endmodule
